// ===== hdl/lzbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbr_pkg
// Shared constants and types for the LZ back-reference stream decoder.
// ----------------------------------------------------------------------------
package lzbr_pkg;

    localparam int WINDOW_BYTES = 131072;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);

    localparam logic [1:0] OP_FEED    = 2'd0;
    localparam logic [1:0] OP_PULL    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;  // reserved, answered as busy

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BUSY     = 4'd1;
    localparam logic [3:0] ST_NEED     = 4'd2;
    localparam logic [3:0] ST_DONE     = 4'd3;
    localparam logic [3:0] ST_BADHDR   = 4'd4;
    localparam logic [3:0] ST_TRUNC    = 4'd5;
    localparam logic [3:0] ST_BADOFS   = 4'd6;
    localparam logic [3:0] ST_OVERFLOW = 4'd7;
    localparam logic [3:0] ST_SIZEMIS  = 4'd8;

    // one request in flight in stage 2, for the output stage
    typedef struct packed {
        logic             valid;
        logic             from_mem;
        logic [7:0]       lit_byte;
        logic [3:0]       status;
        logic [23:0]      count;
    } t_resp;

endpackage

// ===== hdl/lzbr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzbr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lzbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lz_backref_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_backref_stream_decoder_top
// Streaming decoder for a byte-oriented LZ format with back references.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is decoded into stage 2 (history RAM read,
//   registered RAM data), then moves on into the output register.
// Throughput: one request per cycle while the output is not stalled; the single
//   history RAM read and write per cycle bound it. A copy byte read one request
//   after it was written is forwarded past the RAM.
// Reset: synchronous, active low; parser state, stage 2 and output valid clear;
//   the history window is not cleared (reads only reach bytes of this stream).
module lz_backref_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic [23:0] o_produced_count
);
    localparam int AW = lzbr_pkg::WIN_AW;

    typedef enum logic [3:0] {
        PH_MAGIC0, PH_MAGIC1, PH_SIZE, PH_EXTRA, PH_CMD,
        PH_CMDMORE, PH_LIT, PH_TERMLIT, PH_COPY
    } t_phase;

    // parser state
    t_phase      r_phase,  n_phase;
    logic [2:0]  r_bcnt,   n_bcnt;
    logic        r_long,   n_long;
    logic [23:0] r_dsize,  n_dsize;
    logic [23:0] r_opos,   n_opos;
    logic [31:0] r_cmd,    n_cmd;
    logic [6:0]  r_lit,    n_lit;
    logic [10:0] r_copy,   n_copy;
    logic [17:0] r_dist,   n_dist;
    logic [3:0]  r_sticky, n_sticky;

    // stage 2 (RAM read in flight) and output register
    lzbr_pkg::t_resp r_s2, n_s2;
    logic        r_s2_fwd;
    logic        r_s2_lit_flag;   // stage 2 carries an emitted literal byte
    logic [7:0]  r_fwd_byte;
    logic        r_ovalid;
    logic [3:0]  r_ostatus;
    logic        r_oov;
    logic [7:0]  r_obyte;
    logic [23:0] r_ocount;

    logic        s2_adv, out_free, accept;
    logic [7:0]  s2_byte;
    logic [7:0]  ram_q;

    // hold the pipe when the result register is full and stalled
    assign out_free = !r_ovalid || !i_stall;
    assign s2_adv   = out_free;
    assign o_stall  = !out_free;
    assign accept   = i_valid && out_free;

    // write data of stage 2 for copies: RAM data or forwarded byte
    assign s2_byte = !r_s2.from_mem ? r_s2.lit_byte :
                     (r_s2_fwd ? r_fwd_byte : ram_q);

    // decode
    logic            we, re, fwd;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      wdata;
    logic [3:0]      st;
    logic            ov, frommem;
    logic [7:0]      c0, c1, c2, c3, b;
    logic [6:0]      nlit;
    logic [10:0]     len;
    logic [17:0]     cdist;
    logic [24:0]     sum_lit, sum_all;
    logic [31:0]     cmdx;
    logic [2:0]      pk;

    always_comb begin
        n_phase = r_phase; n_bcnt = r_bcnt; n_long = r_long; n_dsize = r_dsize;
        n_opos = r_opos; n_cmd = r_cmd; n_lit = r_lit; n_copy = r_copy;
        n_dist = r_dist; n_sticky = r_sticky;
        we = 1'b0; re = 1'b0; fwd = 1'b0; ov = 1'b0; frommem = 1'b0;
        waddr = r_opos[AW-1:0]; raddr = '0; wdata = i_in_byte;
        st = lzbr_pkg::ST_OK; b = i_in_byte;
        cmdx = r_cmd; c0 = '0; c1 = '0; c2 = '0; c3 = '0;
        nlit = '0; len = '0; cdist = '0; sum_lit = '0; sum_all = '0; pk = '0;
        if (i_opcode == lzbr_pkg::OP_RESTART) begin
            n_phase = PH_MAGIC0; n_bcnt = '0; n_long = 1'b0; n_dsize = '0;
            n_opos = '0; n_cmd = '0; n_lit = '0; n_copy = '0; n_dist = '0;
            n_sticky = '0;
        end else if (i_opcode == lzbr_pkg::OP_UNUSED) begin
            st = lzbr_pkg::ST_BUSY;
        end else if (r_sticky != '0) begin
            st = r_sticky;
        end else if (i_opcode == lzbr_pkg::OP_PULL) begin
            if (r_phase != PH_COPY) begin
                st = lzbr_pkg::ST_NEED;
            end else begin
                // read behind the write pointer; distance never exceeds window
                raddr = AW'(r_opos[AW-1:0] - r_dist[AW-1:0]);
                re = 1'b1; ov = 1'b1; frommem = 1'b1;
                // byte written by the previous request is not yet in the RAM
                fwd = r_s2.valid && r_s2.from_mem && (r_dist == 18'd1);
                n_opos = r_opos + 24'd1;
                n_copy = r_copy - 11'd1;
                if (r_copy == 11'd1) begin
                    n_phase = PH_CMD;
                end
            end
        end else if (r_phase == PH_COPY) begin
            st = lzbr_pkg::ST_BUSY;
        end else begin
            case (r_phase)
                PH_MAGIC0: begin
                    if ((b & 8'hFE) != 8'h10 || i_in_last) begin
                        st = lzbr_pkg::ST_BADHDR;
                    end else begin
                        n_long = b[0]; n_phase = PH_MAGIC1;
                    end
                end
                PH_MAGIC1: begin
                    if (b != 8'hFB || i_in_last) begin
                        st = lzbr_pkg::ST_BADHDR;
                    end else begin
                        n_phase = PH_SIZE; n_bcnt = '0;
                    end
                end
                PH_SIZE: begin
                    n_dsize = {r_dsize[15:0], b};
                    if (r_bcnt < 3'd2) begin
                        n_bcnt = r_bcnt + 3'd1;
                        if (i_in_last) st = lzbr_pkg::ST_BADHDR;
                    end else begin
                        n_bcnt = '0;
                        if (r_long) begin
                            n_phase = PH_EXTRA;
                            if (i_in_last) st = lzbr_pkg::ST_BADHDR;
                        end else begin
                            n_phase = PH_CMD;
                            if (i_in_last) st = lzbr_pkg::ST_TRUNC;
                        end
                    end
                end
                PH_EXTRA: begin
                    if (r_bcnt < 3'd2) begin
                        n_bcnt = r_bcnt + 3'd1;
                        if (i_in_last) st = lzbr_pkg::ST_BADHDR;
                    end else begin
                        n_bcnt = '0; n_phase = PH_CMD;
                        if (i_in_last) st = lzbr_pkg::ST_TRUNC;
                    end
                end
                PH_CMD: begin
                    if (b >= 8'hFC) begin
                        nlit = {5'd0, b[1:0]};
                        sum_lit = {1'b0, r_opos} + 25'(nlit);
                        if (nlit != '0 && i_in_last) begin
                            st = lzbr_pkg::ST_TRUNC;
                        end else if (sum_lit > {1'b0, r_dsize}) begin
                            st = lzbr_pkg::ST_OVERFLOW;
                        end else if (nlit == '0) begin
                            st = (r_opos == r_dsize) ? lzbr_pkg::ST_DONE
                                                     : lzbr_pkg::ST_SIZEMIS;
                        end else begin
                            n_lit = nlit; n_phase = PH_TERMLIT;
                        end
                    end else if (i_in_last) begin
                        st = lzbr_pkg::ST_TRUNC;
                    end else if (b >= 8'hE0) begin
                        nlit = {b[4:0], 2'b00} + 7'd4;
                        sum_lit = {1'b0, r_opos} + 25'(nlit);
                        if (sum_lit > {1'b0, r_dsize}) begin
                            st = lzbr_pkg::ST_OVERFLOW;
                        end else begin
                            n_lit = nlit; n_copy = '0; n_phase = PH_LIT;
                        end
                    end else begin
                        n_cmd = {b, 24'd0}; n_bcnt = 3'd1; n_phase = PH_CMDMORE;
                    end
                end
                PH_CMDMORE: begin
                    case (r_bcnt[1:0])
                        2'd1:    cmdx = r_cmd | {8'd0, b, 16'd0};
                        2'd2:    cmdx = r_cmd | {16'd0, b, 8'd0};
                        2'd3:    cmdx = r_cmd | {24'd0, b};
                        default: cmdx = r_cmd | {b, 24'd0};
                    endcase
                    n_cmd = cmdx;
                    n_bcnt = r_bcnt + 3'd1;
                    c0 = cmdx[31:24]; c1 = cmdx[23:16];
                    c2 = cmdx[15:8];  c3 = cmdx[7:0];
                    pk = (c0 <= 8'h7F) ? 3'd2 : ((c0 <= 8'hBF) ? 3'd3 : 3'd4);
                    if (c0 <= 8'h7F) begin
                        nlit  = {5'd0, c0[1:0]};
                        len   = {8'd0, c0[4:2]} + 11'd3;
                        cdist = {8'd0, c0[6:5], c1} + 18'd1;
                    end else if (c0 <= 8'hBF) begin
                        nlit  = {5'd0, c1[7:6]};
                        len   = {5'd0, c0[5:0]} + 11'd4;
                        cdist = {4'd0, c1[5:0], c2} + 18'd1;
                    end else begin
                        nlit  = {5'd0, c0[1:0]};
                        len   = {1'b0, c0[3:2], c3} + 11'd5;
                        cdist = {1'b0, c0[4], c1, c2} + 18'd1;
                    end
                    sum_lit = {1'b0, r_opos} + 25'(nlit);
                    sum_all = sum_lit + 25'(len);
                    if (i_in_last) begin
                        st = lzbr_pkg::ST_TRUNC;
                    end else if (n_bcnt >= pk) begin
                        n_bcnt = '0;
                        if (25'(cdist) > sum_lit) begin
                            st = lzbr_pkg::ST_BADOFS;
                        end else if (sum_all > {1'b0, r_dsize}) begin
                            st = lzbr_pkg::ST_OVERFLOW;
                        end else begin
                            n_lit = nlit; n_copy = len; n_dist = cdist;
                            n_phase = (nlit != '0) ? PH_LIT : PH_COPY;
                        end
                    end
                end
                PH_LIT, PH_TERMLIT: begin
                    ov = 1'b1; we = 1'b1;
                    n_opos = r_opos + 24'd1;
                    n_lit = r_lit - 7'd1;
                    if (r_lit == 7'd1) begin
                        if (r_phase == PH_TERMLIT) begin
                            st = (n_opos == r_dsize) ? lzbr_pkg::ST_DONE
                                                     : lzbr_pkg::ST_SIZEMIS;
                        end else begin
                            n_phase = (r_copy != '0) ? PH_COPY : PH_CMD;
                        end
                    end
                    if (st == lzbr_pkg::ST_OK && i_in_last) st = lzbr_pkg::ST_TRUNC;
                end
                default: st = lzbr_pkg::ST_BADHDR;
            endcase
            if (st != lzbr_pkg::ST_OK) n_sticky = st;
        end
        n_s2.valid    = 1'b1;
        n_s2.from_mem = frommem;
        n_s2.lit_byte = ov ? i_in_byte : 8'd0;
        n_s2.status   = st;
        n_s2.count    = n_opos;
    end

    // history window; copy bytes are written back from stage 2 when it advances
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] r_s2_addr;
    assign ram_we    = (accept && we) || (s2_adv && r_s2.valid && r_s2.from_mem);
    assign ram_waddr = (accept && we) ? waddr : r_s2_addr;

    lzbr_ram #(.WIDTH(8), .DEPTH(lzbr_pkg::WINDOW_BYTES)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ((accept && we) ? wdata : s2_byte),
        .i_re    (accept && re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC0; r_bcnt <= '0; r_long <= 1'b0; r_dsize <= '0;
            r_opos <= '0; r_cmd <= '0; r_lit <= '0; r_copy <= '0; r_dist <= '0;
            r_sticky <= '0;
            r_s2 <= '0; r_s2_fwd <= 1'b0; r_s2_lit_flag <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (s2_adv) begin
                // advance stage 2 into the result register
                r_ovalid <= r_s2.valid;
                if (r_s2.valid) begin
                    r_ostatus <= r_s2.status;
                    r_oov     <= r_s2.from_mem || r_s2_lit_flag;
                    r_obyte   <= s2_byte;
                    r_ocount  <= r_s2.count;
                end
                r_s2 <= accept ? n_s2 : '0;
                if (accept) begin
                    r_s2_fwd      <= fwd;
                    r_s2_lit_flag <= ov && !frommem;
                    r_fwd_byte    <= s2_byte;
                    r_s2_addr     <= r_opos[AW-1:0];
                end
            end
            if (accept) begin
                r_phase <= n_phase; r_bcnt <= n_bcnt; r_long <= n_long;
                r_dsize <= n_dsize; r_opos <= n_opos; r_cmd <= n_cmd;
                r_lit <= n_lit; r_copy <= n_copy; r_dist <= n_dist;
                r_sticky <= n_sticky;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_out_valid      = r_oov;
    assign o_out_byte       = r_obyte;
    assign o_produced_count = r_ocount;

    // forwarding only ever applies to a copy byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_fwd && r_s2.valid |-> r_s2.from_mem) else $error("fwd without copy");
    // a pull that produced a byte advances the position by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && frommem |=> r_opos == $past(r_opos) + 24'd1) else $error("opos");
    // sticky status never holds the busy or need code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky != lzbr_pkg::ST_BUSY && r_sticky != lzbr_pkg::ST_NEED)
        else $error("sticky code");
endmodule

// ===== verif/lz_backref_stream_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_backref_stream_decoder_top_test
// Self-checking bench for the LZ back-reference stream decoder. A per-request
// decode model runs alongside the block. Every accepted request pushes the
// response the model predicts, and a monitor compares each response that the
// block returns. Stimulus is directed header, packet and error cases, then
// well-formed random streams with some corrupted ones, random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module lz_backref_stream_decoder_top_test;

    localparam logic [7:0] MAGIC_LO   = 8'h10;  // first magic byte, bit 0 = long header
    localparam logic [7:0] MAGIC_HI   = 8'hFB;
    localparam logic [7:0] CMD_LITRUN = 8'hE0;  // literal run, count in bits 4:0
    localparam logic [7:0] CMD_TERM   = 8'hFC;  // terminator, literals in bits 1:0
    localparam int         PKT_SHORT  = 0;
    localparam int         PKT_MID    = 1;
    localparam int         PKT_LONG   = 2;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 300;

    typedef enum logic [3:0] {
        P_MAGIC0, P_MAGIC1, P_SIZE, P_EXTRA, P_CMD, P_CMDMORE, P_LIT, P_TERMLIT, P_COPY
    } t_phase;

    typedef struct {
        logic [3:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [23:0] count;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_status;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [23:0] o_produced_count;

    lz_backref_stream_decoder_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_in_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_produced_count (o_produced_count)
    );

    // Decoder model state: one copy of everything the block keeps per stream
    t_phase     m_phase;
    int         m_cnt;
    logic       m_long;
    int         m_size;
    int         m_pos;
    logic [31:0] m_cmd;
    int         m_lits;
    int         m_copy;
    int         m_dist;
    logic [3:0] m_sticky;
    logic [7:0] m_history [lzbr_pkg::WINDOW_BYTES];

    t_response  awaited_responses[$];
    int         errors;
    int         requests_sent;
    int         responses_checked;
    int         streams_run;
    int         cycles;
    bit         idle_on;
    bit         hold_req;
    int         corrupt_in;   // feeds left before one byte is corrupted, -1 = off

    // ------------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------------
    function automatic void clear_stream();
        m_phase  = P_MAGIC0;
        m_cnt    = 0;
        m_long   = 1'b0;
        m_size   = 0;
        m_pos    = 0;
        m_cmd    = '0;
        m_lits   = 0;
        m_copy   = 0;
        m_dist   = 0;
        m_sticky = lzbr_pkg::ST_OK;
    endfunction

    function automatic logic [3:0] latch_status(logic [3:0] s);
        m_sticky = s;
        return s;
    endfunction

    function automatic logic [3:0] close_stream();
        return latch_status(m_pos == m_size ? lzbr_pkg::ST_DONE : lzbr_pkg::ST_SIZEMIS);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        m_history[m_pos % lzbr_pkg::WINDOW_BYTES] = b;
        m_pos = (m_pos + 1) & 24'hFFFFFF;
    endfunction

    // Decode a complete copy packet held in m_cmd
    function automatic logic [3:0] open_copy();
        int c0, c1, c2, c3, nlit, len, cdist;
        c0 = m_cmd[31:24];
        c1 = m_cmd[23:16];
        c2 = m_cmd[15:8];
        c3 = m_cmd[7:0];
        if (c0 <= 8'h7F) begin
            nlit  = c0 & 3;
            len   = ((c0 >> 2) & 7) + 3;
            cdist = ((c0 & 8'h60) << 3) + c1 + 1;
        end else if (c0 <= 8'hBF) begin
            nlit  = (c1 >> 6) & 3;
            len   = (c0 & 8'h3F) + 4;
            cdist = ((c1 & 8'h3F) << 8) + c2 + 1;
        end else begin
            nlit  = c0 & 3;
            len   = ((c0 & 8'h0C) << 6) + c3 + 5;
            cdist = ((c0 & 8'h10) << 12) + (c1 << 8) + c2 + 1;
        end
        if (cdist > m_pos + nlit)
            return latch_status(lzbr_pkg::ST_BADOFS);
        if (m_pos + nlit + len > m_size)
            return latch_status(lzbr_pkg::ST_OVERFLOW);
        m_lits  = nlit;
        m_copy  = len;
        m_dist  = cdist;
        m_phase = nlit != 0 ? P_LIT : P_COPY;
        return lzbr_pkg::ST_OK;
    endfunction

    function automatic logic [3:0] decode_feed(logic [7:0] b, logic last, output logic v);
        int n;
        v = 1'b0;
        case (m_phase)
            P_MAGIC0: begin
                if ((b & 8'hFE) != MAGIC_LO || last)
                    return latch_status(lzbr_pkg::ST_BADHDR);
                m_long  = b[0];
                m_phase = P_MAGIC1;
                return lzbr_pkg::ST_OK;
            end
            P_MAGIC1: begin
                if (b != MAGIC_HI || last)
                    return latch_status(lzbr_pkg::ST_BADHDR);
                m_phase = P_SIZE;
                m_cnt   = 0;
                return lzbr_pkg::ST_OK;
            end
            P_SIZE: begin
                m_size = ((m_size << 8) | b) & 24'hFFFFFF;
                m_cnt++;
                if (m_cnt < 3)
                    return last ? latch_status(lzbr_pkg::ST_BADHDR) : lzbr_pkg::ST_OK;
                m_cnt = 0;
                if (m_long) begin
                    m_phase = P_EXTRA;
                    return last ? latch_status(lzbr_pkg::ST_BADHDR) : lzbr_pkg::ST_OK;
                end
                m_phase = P_CMD;
                return last ? latch_status(lzbr_pkg::ST_TRUNC) : lzbr_pkg::ST_OK;
            end
            P_EXTRA: begin
                m_cnt++;
                if (m_cnt < 3)
                    return last ? latch_status(lzbr_pkg::ST_BADHDR) : lzbr_pkg::ST_OK;
                m_cnt   = 0;
                m_phase = P_CMD;
                return last ? latch_status(lzbr_pkg::ST_TRUNC) : lzbr_pkg::ST_OK;
            end
            P_CMD: begin
                if (b >= CMD_TERM) begin
                    n = b & 3;
                    if (n != 0 && last)
                        return latch_status(lzbr_pkg::ST_TRUNC);
                    if (m_pos + n > m_size)
                        return latch_status(lzbr_pkg::ST_OVERFLOW);
                    if (n == 0)
                        return close_stream();
                    m_lits  = n;
                    m_phase = P_TERMLIT;
                    return lzbr_pkg::ST_OK;
                end
                if (last)
                    return latch_status(lzbr_pkg::ST_TRUNC);
                if (b >= CMD_LITRUN) begin
                    n = ((b & 8'h1F) << 2) + 4;
                    if (m_pos + n > m_size)
                        return latch_status(lzbr_pkg::ST_OVERFLOW);
                    m_lits  = n;
                    m_copy  = 0;
                    m_phase = P_LIT;
                    return lzbr_pkg::ST_OK;
                end
                m_cmd   = {b, 24'd0};
                m_cnt   = 1;
                m_phase = P_CMDMORE;
                return lzbr_pkg::ST_OK;
            end
            P_CMDMORE: begin
                m_cmd = m_cmd | ({24'd0, b} << (8 * (3 - (m_cnt & 3))));
                m_cnt++;
                if (last)
                    return latch_status(lzbr_pkg::ST_TRUNC);
                n = m_cmd[31:24] <= 8'h7F ? 2 : (m_cmd[31:24] <= 8'hBF ? 3 : 4);
                if (m_cnt < n)
                    return lzbr_pkg::ST_OK;
                m_cnt = 0;
                return open_copy();
            end
            P_LIT, P_TERMLIT: begin
                v = 1'b1;
                store_byte(b);
                m_lits = (m_lits - 1) & 8'h7F;
                if (m_lits == 0) begin
                    if (m_phase == P_TERMLIT)
                        return close_stream();
                    m_phase = m_copy != 0 ? P_COPY : P_CMD;
                end
                return last ? latch_status(lzbr_pkg::ST_TRUNC) : lzbr_pkg::ST_OK;
            end
            default: return latch_status(lzbr_pkg::ST_BADHDR);
        endcase
    endfunction

    function automatic t_response decode_request(logic [1:0] op, logic [7:0] b, logic last);
        t_response r;
        logic      v;
        int        wr, rd;
        r = '{status: lzbr_pkg::ST_OK, out_valid: 1'b0, out_byte: 8'd0, count: 24'd0};
        if (op == lzbr_pkg::OP_RESTART) begin
            clear_stream();
        end else if (op == lzbr_pkg::OP_UNUSED) begin
            r.status = lzbr_pkg::ST_BUSY;
        end else if (m_sticky != lzbr_pkg::ST_OK) begin
            r.status = m_sticky;
        end else if (op == lzbr_pkg::OP_FEED) begin
            if (m_phase == P_COPY) begin
                r.status = lzbr_pkg::ST_BUSY;
            end else begin
                r.status = decode_feed(b, last, v);
                r.out_valid = v;
                if (v)
                    r.out_byte = b;
            end
        end else if (m_phase != P_COPY) begin
            r.status = lzbr_pkg::ST_NEED;
        end else begin
            wr = m_pos % lzbr_pkg::WINDOW_BYTES;
            rd = (wr + lzbr_pkg::WINDOW_BYTES - (m_dist % (lzbr_pkg::WINDOW_BYTES + 1)))
                 % lzbr_pkg::WINDOW_BYTES;
            r.out_byte  = m_history[rd];
            r.out_valid = 1'b1;
            store_byte(r.out_byte);
            m_copy = (m_copy - 1) & 11'h7FF;
            if (m_copy == 0)
                m_phase = P_CMD;
        end
        r.count = m_pos[23:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge i_clk) begin
        t_response exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_responses.size() == 0) begin
                $display("%0t: response with none expected: status %0d byte %0d", $time,
                         o_status, o_out_byte);
                errors++;
            end else begin
                exp_r = awaited_responses.pop_front();
                responses_checked++;
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             o_status);
                    errors++;
                end
                if (o_out_valid !== exp_r.out_valid) begin
                    $display("%0t: out_valid expected %0d actual %0d", $time,
                             exp_r.out_valid, o_out_valid);
                    errors++;
                end
                if (o_out_byte !== exp_r.out_byte) begin
                    $display("%0t: out_byte expected %0h actual %0h", $time,
                             exp_r.out_byte, o_out_byte);
                    errors++;
                end
                if (o_produced_count !== exp_r.count) begin
                    $display("%0t: produced_count expected %0d actual %0d", $time,
                             exp_r.count, o_produced_count);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request, hold it until accepted, then predict its response.
    // Valid stays high for a back-to-back request; a gap lowers it.
    task automatic send_req(logic [1:0] op, logic [7:0] b, logic last);
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall);
        awaited_responses.push_back(decode_request(op, b, last));
        requests_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Feed one compressed byte, corrupting it if this is the chosen one
    task automatic feed_byte(logic [7:0] b, logic last);
        if (corrupt_in == 0) begin
            b    = 8'($urandom);
            last = 1'($urandom_range(0, 1));
        end
        if (corrupt_in >= 0)
            corrupt_in--;
        send_req(lzbr_pkg::OP_FEED, b, last);
    endtask

    task automatic feed_header(int size, logic lng, logic last_at_end);
        feed_byte(MAGIC_LO | lng, 1'b0);
        feed_byte(MAGIC_HI, 1'b0);
        feed_byte(8'(size >> 16), 1'b0);
        feed_byte(8'(size >> 8), 1'b0);
        feed_byte(8'(size), last_at_end && !lng);
        if (lng) begin
            feed_byte(8'($urandom), 1'b0);
            feed_byte(8'($urandom), 1'b0);
            feed_byte(8'($urandom), last_at_end);
        end
    endtask

    // Send a copy packet, its literals, and pull the copy; sometimes poke a
    // feed in while the copy is pending (refused as busy)
    task automatic send_copy(int kind, int nlit, int len, int cdist);
        int d, l;
        d = cdist - 1;
        l = len - 5;
        case (kind)
            PKT_SHORT: begin
                feed_byte(8'((((d >> 8) & 3) << 5) | ((len - 3) << 2) | nlit), 1'b0);
                feed_byte(8'(d), 1'b0);
            end
            PKT_MID: begin
                feed_byte(8'(8'h80 | (len - 4)), 1'b0);
                feed_byte(8'((nlit << 6) | ((d >> 8) & 8'h3F)), 1'b0);
                feed_byte(8'(d), 1'b0);
            end
            default: begin
                feed_byte(8'(8'hC0 | (((d >> 16) & 1) << 4) | (((l >> 8) & 3) << 2) | nlit),
                          1'b0);
                feed_byte(8'(d >> 8), 1'b0);
                feed_byte(8'(d), 1'b0);
                feed_byte(8'(l), 1'b0);
            end
        endcase
        repeat (nlit) feed_byte(8'($urandom), 1'b0);
        repeat (len) begin
            if (m_sticky != lzbr_pkg::ST_OK)
                break;
            if ($urandom_range(0, 15) == 0)
                send_req(lzbr_pkg::OP_FEED, 8'($urandom), 1'($urandom_range(0, 1)));
            send_req(lzbr_pkg::OP_PULL, 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // One well-formed stream of the given size, random packet mix
    task automatic run_stream(int size, logic lng);
        int rem, kind, tmin, tmax, dmax, nlit, lmax, len, dcap, cdist, k, guard;
        streams_run++;
        send_req(lzbr_pkg::OP_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
        feed_header(size, lng, 1'b0);
        guard = 0;
        while (m_sticky == lzbr_pkg::ST_OK && guard < 300) begin
            guard++;
            // a corrupted command byte may leave a copy pending: pull it out
            if (m_phase == P_COPY) begin
                send_req(lzbr_pkg::OP_PULL, 8'd0, 1'b0);
                continue;
            end
            rem = size - m_pos;
            if (rem < 0)
                break;
            if ($urandom_range(0, 12) == 0)
                send_req($urandom_range(0, 1) ? lzbr_pkg::OP_PULL : lzbr_pkg::OP_UNUSED,
                         8'($urandom), 1'b0);
            if (rem <= 3) begin
                feed_byte(8'(CMD_TERM | rem), rem == 0);
                for (k = 0; k < rem; k++)
                    feed_byte(8'($urandom), k == rem - 1);
                break;
            end
            kind = $urandom_range(0, 3);
            tmin = kind == 1 ? 3 : (kind == 2 ? 4 : 5);
            if (kind == 0 || m_pos == 0 || rem < tmin) begin
                k = (rem - 4) / 4 > 27 ? 27 : (rem - 4) / 4;
                k = $urandom_range(0, k);
                feed_byte(8'(CMD_LITRUN | k), 1'b0);
                repeat (4 * k + 4) feed_byte(8'($urandom), 1'b0);
            end else begin
                tmax = kind == 1 ? 10 : (kind == 2 ? 67 : 1028);
                dmax = kind == 1 ? 1024 : (kind == 2 ? 16384 : 131072);
                nlit = $urandom_range(0, rem - tmin > 3 ? 3 : rem - tmin);
                lmax = rem - nlit > tmax ? tmax : rem - nlit;
                if ($urandom_range(0, 2) == 0)
                    len = $urandom_range(tmin, lmax);
                else
                    len = $urandom_range(tmin, lmax > tmin + 6 ? tmin + 6 : lmax);
                dcap  = m_pos + nlit > dmax ? dmax : m_pos + nlit;
                cdist = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, dcap);
                send_copy(kind - 1, nlit, len, cdist);
            end
        end
        // bytes after the end are answered with the sticky status
        if ($urandom_range(0, 3) == 0)
            feed_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Lower valid and wait for every prediction to be answered
    task automatic drain();
        i_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_header_checks();
        send_req(lzbr_pkg::OP_PULL, 8'h00, 1'b0);      // nothing to copy: need input
        send_req(lzbr_pkg::OP_UNUSED, 8'hFF, 1'b1);    // unknown opcode: busy
        send_req(lzbr_pkg::OP_FEED, 8'h12, 1'b0);      // wrong magic
        send_req(lzbr_pkg::OP_FEED, MAGIC_LO, 1'b0);   // ignored while sticky
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);
        send_req(lzbr_pkg::OP_FEED, MAGIC_LO, 1'b1);   // last on an early header byte
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);
        feed_header(0, 1'b0, 1'b1);                    // last on the final header byte
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);
        feed_header(24'hFFFFFF, 1'b1, 1'b1);           // long header, truncated
    endtask

    // Every packet form, overlapping copy, busy feeds at random, terminator with literals
    task automatic test_packet_forms();
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);
        feed_header(22, 1'b0, 1'b0);
        feed_byte(CMD_LITRUN, 1'b0);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h55, 1'b0);
        feed_byte(8'hAA, 1'b0);
        send_copy(PKT_SHORT, 0, 3, 1);
        send_copy(PKT_MID, 1, 4, 7);
        send_copy(PKT_LONG, 2, 5, 14);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h01, 1'b0);
        feed_byte(8'h80, 1'b0);
        feed_byte(8'hFE, 1'b0);
    endtask

    task automatic test_stream_errors();
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // offset beyond output
        feed_header(10, 1'b0, 1'b0);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'h04, 1'b0);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // literal run beyond declared size
        feed_header(4, 1'b0, 1'b0);
        feed_byte(CMD_LITRUN | 8'h01, 1'b0);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // terminator with bytes missing
        feed_header(5, 1'b1, 1'b0);
        feed_byte(CMD_TERM, 1'b1);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // literal with last: emitted, truncated
        feed_header(8, 1'b0, 1'b0);
        feed_byte(CMD_LITRUN, 1'b0);
        feed_byte(8'h3C, 1'b1);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // terminator literals with last
        feed_header(2, 1'b0, 1'b0);
        feed_byte(CMD_TERM | 8'h02, 1'b1);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // terminator literals overflow
        feed_header(1, 1'b0, 1'b0);
        feed_byte(CMD_TERM | 8'h03, 1'b0);
        send_req(lzbr_pkg::OP_RESTART, 8'h00, 1'b0);   // copy packet overflow
        feed_header(6, 1'b0, 1'b0);
        feed_byte(CMD_LITRUN, 1'b0);
        repeat (4) feed_byte(8'($urandom), 1'b0);
        send_copy(PKT_SHORT, 0, 3, 2);
    endtask

    // Hold the output off for a long stretch while streams keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        run_stream(60, 1'b0);
        run_stream(30, 1'b1);
    endtask

    task automatic test_random_streams();
        int size;
        while (requests_sent < 500) begin
            if (requests_sent > 430)
                idle_on = 1'b0;        // final stretch at full rate
            size = $urandom_range(0, 9) == 0 ? $urandom_range(100, 200)
                                             : $urandom_range(0, 50);
            corrupt_in = $urandom_range(0, 5) == 0 ? $urandom_range(0, size / 2 + 8) : -1;
            run_stream(size, 1'($urandom_range(0, 1)));
        end
        corrupt_in = -1;
    endtask

    initial begin
        errors            = 0;
        requests_sent     = 0;
        responses_checked = 0;
        streams_run       = 0;
        cycles            = 0;
        idle_on           = 1'b1;
        hold_req          = 1'b0;
        corrupt_in        = -1;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_opcode          = lzbr_pkg::OP_FEED;
        i_in_byte         = 8'd0;
        i_in_last         = 1'b0;
        clear_stream();
        for (int a = 0; a < lzbr_pkg::WINDOW_BYTES; a++)
            m_history[a] = 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_checks();
        drain();
        test_packet_forms();
        drain();
        test_stream_errors();
        drain();
        test_backpressure();
        drain();
        test_random_streams();
        drain();

        $display("Ran %0d streams: %0d requests sent, %0d responses checked, %0d mismatches",
                 streams_run, requests_sent, responses_checked, errors);
        $display("Covered header checks, all packet forms, stream errors and back-pressure");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
